@@ rtl/trial_division_factorizer_core_assert.svh @@
// assertion macros for the trial division factorizer
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge out of reset
`define TDF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tdf assertion failed");
// check that an antecedent implies a consequent in the same cycle
`define TDF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tdf implication failed");
`else
`define TDF_ASSERT(label, prop)
`define TDF_ASSERT_IMPL(label, ante, cons)
`endif

`endif

@@ rtl/tdf_pkg.sv @@
// shared constants and types for the trial division factorizer
`default_nettype none

package tdf_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int FACTOR_BITS = VALUE_BITS - 1;
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((FACTOR_BITS + 7) / 8) * 8;
    localparam int CNT_BITS    = $clog2(FACTOR_BITS + 1);

    localparam logic [FACTOR_BITS-1:0] FACTOR_ERROR   = FACTOR_BITS'(0);
    localparam logic [FACTOR_BITS-1:0] FACTOR_NONE    = FACTOR_BITS'(1);
    localparam logic [FACTOR_BITS-1:0] FIRST_DIVISOR  = FACTOR_BITS'(2);

    typedef logic [FACTOR_BITS-1:0] factor_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/tdf_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module tdf_divider (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire tdf_pkg::factor_t     dividend,
    input  wire tdf_pkg::factor_t     divisor,
    output tdf_pkg::factor_t          quot,
    output tdf_pkg::factor_t          rem,
    output tdf_pkg::div_status_t      status
);
    import tdf_pkg::*;

    factor_t                quot_reg, quot_next;
    factor_t                rem_reg, rem_next;
    factor_t                divisor_reg, divisor_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [FACTOR_BITS:0]   rem_shift;
    logic [FACTOR_BITS:0]   rem_diff;

    always_comb begin
        rem_shift    = {rem_reg, quot_reg[FACTOR_BITS-1]};
        rem_diff     = rem_shift - {1'b0, divisor_reg};
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        if (start) begin
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = CNT_BITS'(FACTOR_BITS);
        end else if (cnt_reg != '0) begin
            // shift in the next dividend bit, subtract when it fits
            if (rem_shift >= {1'b0, divisor_reg}) begin
                rem_next  = rem_diff[FACTOR_BITS-1:0];
                quot_next = {quot_reg[FACTOR_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[FACTOR_BITS-1:0];
                quot_next = {quot_reg[FACTOR_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign quot        = quot_reg;
    assign rem         = rem_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/trial_division_factorizer_core.sv @@
// top level of the trial division factorizer: sequencer and output register
// each trial divisor is one full division in the bit-serial divider (ST_DIV, ST_WAIT);
// divisors are tried upward from two until one divides n or exceeds its square root,
// and each factor found is loaded into the output register from ST_EMIT
// throughput: one item at a time, the next taken once the last result is loaded
// reset (aresetn low, synchronous) returns to idle and empties the output register
`default_nettype none
`include "trial_division_factorizer_core_assert.svh"

module trial_division_factorizer_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tdf_pkg::S_TDATA_BITS-1:0] s_tdata,   // [31:0] value
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tdf_pkg::M_TDATA_BITS-1:0]      m_tdata,   // [30:0] factor
    output logic                                  m_tlast
);
    import tdf_pkg::*;

    state_t         state_reg, state_next;
    factor_t        n_reg, n_next;
    factor_t        d_reg, d_next;
    factor_t        emit_val_reg, emit_val_next;
    logic           emit_last_reg, emit_last_next;
    logic           m_tvalid_reg, m_tvalid_next;
    factor_t        m_factor_reg, m_factor_next;
    logic           m_tlast_reg, m_tlast_next;
    logic           div_start;
    factor_t        div_quot;
    factor_t        div_rem;
    div_status_t    div_stat;
    logic           out_free;
    logic [VALUE_BITS-1:0] in_value;

    tdf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quot     (div_quot),
        .rem      (div_rem),
        .status   (div_stat)
    );

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        emit_val_next  = emit_val_reg;
        emit_last_next = emit_last_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_factor_next  = m_factor_reg;
        m_tlast_next   = m_tlast_reg;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next         = in_value[FACTOR_BITS-1:0];
                    d_next         = FIRST_DIVISOR;
                    emit_last_next = 1'b1;
                    if (in_value[VALUE_BITS-1] || in_value == '0) begin
                        emit_val_next = FACTOR_ERROR;
                        state_next    = ST_EMIT;
                    end else if (in_value == VALUE_BITS'(1)) begin
                        emit_val_next = FACTOR_NONE;
                        state_next    = ST_EMIT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    if (d_reg > div_quot) begin
                        // divisor squared exceeds n: what is left is prime
                        emit_val_next  = n_reg;
                        emit_last_next = 1'b1;
                        state_next     = ST_EMIT;
                    end else if (div_rem == '0) begin
                        emit_val_next  = d_reg;
                        emit_last_next = 1'b0;
                        n_next         = div_quot;
                        state_next     = ST_EMIT;
                    end else begin
                        d_next     = d_reg + FACTOR_BITS'(1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_factor_next = emit_val_reg;
                    m_tlast_next  = emit_last_reg;
                    state_next    = emit_last_reg ? ST_IDLE : ST_DIV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        emit_val_reg  <= emit_val_next;
        emit_last_reg <= emit_last_next;
        m_factor_reg  <= m_factor_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_factor_reg);
    assign m_tlast  = m_tlast_reg;

    // no division may be running while a new item can be taken
    `TDF_ASSERT_IMPL(a_idle_div_quiet, s_tready, !div_stat.busy)
    // divider completion only seen while waiting on it
    `TDF_ASSERT_IMPL(a_done_in_wait, div_stat.done, state_reg == ST_WAIT)
    // trial divisor never below two during a division
    `TDF_ASSERT_IMPL(a_divisor_min, state_reg == ST_WAIT, d_reg >= FIRST_DIVISOR)
    // error and no-factor codes always end the run
    `TDF_ASSERT_IMPL(a_code_is_last, m_tvalid && m_factor_reg <= FACTOR_NONE, m_tlast)

endmodule

`default_nettype wire
